>>> design/signed_int_to_radix_digits_defines.svh
// Assertion macros shared by the signed_int_to_radix_digits RTL files.
// The macros expect a clock named clk and an active-low reset named rst_n.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH
`ifndef SYNTHESIS
`define SITRD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitrd assertion failed");
`define SITRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitrd assertion failed");
`else
`define SITRD_ASSERT(label, ante, cons)
`define SITRD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/sitrd_pkg.sv
// Package for signed_int_to_radix_digits: widths, character codes, register
// indexes, shared types and the alphabet byte lookup. No dependencies.
package sitrd_pkg;

    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int ALPHA_BYTES = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int SP_W        = 6;
    localparam int STACK_AW    = 5;
    localparam int STACK_DEPTH = 32;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;
    localparam int CHUNK_W     = 2;
    localparam int CHUNK_BITS  = 8;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd1;

    localparam logic [CHUNK_W-1:0] CHUNK_LAST = 2'd3;

    typedef struct packed {
        logic                 neg;
        logic [DATA_W-1:0]    mag;
        logic [RADIX_W-1:0]   radix;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SIGN,
        B_EMIT
    } back_state_t;

    function automatic logic [CHAR_W-1:0] alpha_byte(
        input logic [CFG_W-1:0]   lo,
        input logic [CFG_W-1:0]   hi,
        input logic [DIGIT_W-1:0] k
    );
        logic [CFG_W-1:0] w;
        w = k[DIGIT_W-1] ? hi : lo;
        return w[{k[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

>>> design/sitrd_front.sv
// Front end: takes input beats, checks the alphabet and finds the radix,
// and queues the sign, magnitude and radix of each number. Uses sitrd_pkg.
module sitrd_front
    import sitrd_pkg::*;
#(
    parameter int MAX_RADIX = 16
)
(
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   value,
    input  logic [CFG_W-1:0]    digits_low,
    input  logic [CFG_W-1:0]    digits_high,
    input  fifo_stat_t          fifo_stat,
    output logic                push,
    output job_t                job
);

    logic [CHAR_W-1:0]  alpha [ALPHA_BYTES];
    logic [RADIX_W-1:0] radix;
    logic               found;
    logic               bad;

    always_comb
    begin
        radix = RADIX_W'(MAX_RADIX);
        found = 1'b0;
        for (int i = 0; i < ALPHA_BYTES; i++)
        begin
            alpha[i] = alpha_byte(digits_low, digits_high, DIGIT_W'(i));
            if (!found && (alpha[i] == '0 || i >= MAX_RADIX))
            begin
                radix = RADIX_W'(i);
                found = 1'b1;
            end
        end
        bad = (radix < RADIX_W'(2));
        for (int i = 0; i < ALPHA_BYTES; i++)
        begin
            if (RADIX_W'(i) < radix && (alpha[i] == CHAR_PLUS || alpha[i] == CHAR_MINUS))
            begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < ALPHA_BYTES; j++)
            begin
                if (RADIX_W'(j) < radix && alpha[i] == alpha[j])
                begin
                    bad = 1'b1;
                end
            end
        end
    end

    assign s_axis_tready = !fifo_stat.full;
    assign push          = s_axis_tvalid && !fifo_stat.full && !bad;
    assign job.neg       = value[DATA_W-1];
    assign job.mag       = value[DATA_W-1] ? (DATA_W'(0) - value) : value;
    assign job.radix     = radix;

endmodule

>>> design/sitrd_fifo.sv
// Two-entry queue of classified numbers between the front and back ends.
// Uses sitrd_pkg and the assertion macros header.
`include "signed_int_to_radix_digits_defines.svh"
module sitrd_fifo
    import sitrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  job_t        push_job,
    input  logic        pop,
    output job_t        pop_job,
    output fifo_stat_t  stat
);

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;

    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `SITRD_ASSERT(a_push_not_full, push, !stat.full)
    `SITRD_ASSERT(a_pop_not_empty, pop, !stat.empty)

endmodule

>>> design/sitrd_back.sv
// Back end: divides each queued magnitude by the radix digit by digit, stacks
// the digits, then sends the sign and the digits out. Uses sitrd_pkg.
`include "signed_int_to_radix_digits_defines.svh"
module sitrd_back
    import sitrd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  fifo_stat_t          fifo_stat,
    input  job_t                job,
    output logic                pop,
    input  logic [CFG_W-1:0]    digits_low,
    input  logic [CFG_W-1:0]    digits_high,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [CHAR_W-1:0]   m_axis_tdata,
    output logic                m_axis_tlast
);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    quo_next;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_next;
    logic [SP_W-1:0]      sp_reg;
    logic [SP_W-1:0]      sp_next;
    logic [CHUNK_W-1:0]   chunk_reg;
    logic [CHUNK_W-1:0]   chunk_next;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;

    logic [DIGIT_W-1:0]   stack_reg [STACK_DEPTH];
    logic                 stack_we;
    logic [SP_W-1:0]      sp_dec;

    logic [RADIX_W-1:0]   div_r;
    logic [CHUNK_BITS-1:0] div_q;
    logic [DATA_W-1:0]    quo_shift;

    logic                 slot_free;
    logic                 out_load;
    logic [CHAR_W-1:0]    out_char;
    logic                 out_last;

    // Eight restoring steps of the short division per cycle, most significant bits first.
    always_comb
    begin
        div_r = {1'b0, rem_reg};
        div_q = '0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            div_r = {div_r[RADIX_W-2:0], quo_reg[DATA_W-1-i]};
            if (div_r >= radix_reg)
            begin
                div_r = div_r - radix_reg;
                div_q[CHUNK_BITS-1-i] = 1'b1;
            end
        end
        quo_shift = {quo_reg[DATA_W-CHUNK_BITS-1:0], div_q};
    end

    assign sp_dec    = sp_reg - 1'b1;
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        sp_next    = sp_reg;
        chunk_next = chunk_reg;
        pop        = 1'b0;
        stack_we   = 1'b0;
        out_load   = 1'b0;
        out_char   = CHAR_MINUS;
        out_last   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop        = 1'b1;
                    quo_next   = job.mag;
                    rem_next   = '0;
                    neg_next   = job.neg;
                    radix_next = job.radix;
                    sp_next    = '0;
                    chunk_next = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                quo_next   = quo_shift;
                rem_next   = div_r[DIGIT_W-1:0];
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_LAST)
                begin
                    stack_we = 1'b1;
                    sp_next  = sp_reg + 1'b1;
                    rem_next = '0;
                    if (quo_shift == '0)
                    begin
                        state_next = neg_reg ? B_SIGN : B_EMIT;
                    end
                end
            end
            B_SIGN:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_char   = CHAR_MINUS;
                    out_last   = 1'b0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    out_char = alpha_byte(digits_low, digits_high,
                                          stack_reg[sp_dec[STACK_AW-1:0]]);
                    out_last = (sp_reg == SP_W'(1));
                    sp_next  = sp_dec;
                    if (sp_reg == SP_W'(1))
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sp_reg        <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            chunk_reg <= chunk_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        if (out_load)
        begin
            char_reg <= out_char;
            last_reg <= out_last;
        end
        if (stack_we)
        begin
            stack_reg[sp_reg[STACK_AW-1:0]] <= div_r[DIGIT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;

    `SITRD_ASSERT(a_sp_in_range, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `SITRD_ASSERT(a_emit_has_digit, state_reg == B_EMIT, sp_reg != '0)
    `SITRD_ASSERT(a_div_radix_valid, state_reg == B_DIV, radix_reg >= RADIX_W'(2))
    `SITRD_ASSERT_NEXT(a_last_ends_number, out_load && out_last, state_reg == B_IDLE)

endmodule

>>> design/signed_int_to_radix_digits.sv
// Each digit comes from the short divider (eight quotient bits a cycle), then each character
// goes out through the output register. New numbers are taken in while one is still in work,
// as long as the queue ahead of the divider has room; it holds two more numbers. Reset clears
// the alphabet to zeros, which is invalid and drops items, empties the queue and leaves no
// beat pending.
module signed_int_to_radix_digits
    import sitrd_pkg::*;
#(
    parameter int MAX_RADIX = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] value
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [CHAR_W-1:0]    m_axis_tdata,   // [7:0] character
    output logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] digits_low_reg;
    logic [CFG_W-1:0] digits_high_reg;
    fifo_stat_t       fifo_stat;
    logic             push;
    logic             pop;
    job_t             push_job;
    job_t             pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_low_reg  <= '0;
            digits_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIGITS_LOW:  digits_low_reg  <= cfg_data;
                CFG_DIGITS_HIGH: digits_high_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    sitrd_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .value         (s_axis_tdata),
        .digits_low    (digits_low_reg),
        .digits_high   (digits_high_reg),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .job           (push_job)
    );

    sitrd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (fifo_stat)
    );

    sitrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_stat     (fifo_stat),
        .job           (pop_job),
        .pop           (pop),
        .digits_low    (digits_low_reg),
        .digits_high   (digits_high_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> tb/signed_int_to_radix_digits_checker.sv
// Checker for signed_int_to_radix_digits: follows the alphabet writes, predicts the
// characters of every accepted value and compares them with the output beats.
// Depends on sitrd_pkg for widths and character codes.
`timescale 1ns / 1ps

module signed_int_to_radix_digits_checker
    import sitrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [CHAR_W-1:0]    m_axis_tdata,
    input  logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    logic [CFG_W-1:0] alpha_lo;
    logic [CFG_W-1:0] alpha_hi;
    char_beat_t       text_q[$];
    int               errors = 0;

    task automatic predict_text(input logic [DATA_W-1:0] raw);
        logic [CHAR_W-1:0] sym [ALPHA_BYTES];
        logic [CHAR_W-1:0] digit_buf [DATA_W];
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] base;
        int                radix;
        int                nd;
        int                i;
        int                j;
        int                d;
        bit                bad;
        for (i = 0; i < ALPHA_BYTES; i++)
        begin
            sym[i] = (i < 8) ? alpha_lo[8*i +: 8] : alpha_hi[8*(i-8) +: 8];
        end
        radix = 0;
        while (radix < ALPHA_BYTES && sym[radix] != 8'h00)
        begin
            radix++;
        end
        bad = (radix < 2);
        for (i = 0; i < radix; i++)
        begin
            if (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS)
            begin
                bad = 1'b1;
            end
            for (j = i + 1; j < radix; j++)
            begin
                if (sym[j] == sym[i])
                begin
                    bad = 1'b1;
                end
            end
        end
        if (bad)
        begin
            return;
        end
        base = radix;
        mag  = raw[DATA_W-1] ? (32'd0 - raw) : raw;
        nd   = 0;
        do
        begin
            d = int'(mag % base);
            digit_buf[nd] = sym[d];
            mag = mag / base;
            nd++;
        end
        while (mag != 0 && nd < DATA_W);
        if (raw[DATA_W-1])
        begin
            text_q.push_back('{ch: CHAR_MINUS, last: 1'b0});
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            text_q.push_back('{ch: digit_buf[i], last: (i == 0)});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        char_beat_t want;
        if (!rst_n)
        begin
            alpha_lo = '0;
            alpha_hi = '0;
            text_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (text_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("%0t: unexpected beat: character %02h last %0b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    end
                    errors++;
                end
                else
                begin
                    want = text_q.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: expected character %02h last %0b, got %02h last %0b",
                                     $realtime, want.ch, want.last, m_axis_tdata,
                                     m_axis_tlast);
                        end
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_text(s_axis_tdata);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIGITS_LOW:  alpha_lo = cfg_data;
                    CFG_DIGITS_HIGH: alpha_hi = cfg_data;
                    default: ;
                endcase
            end
            pending    <= text_q.size();
            fail_count <= errors;
        end
    end

endmodule

>>> tb/signed_int_to_radix_digits_tb.sv
// Top of the signed_int_to_radix_digits testbench: clock, reset, alphabet writes and
// value stimulus with random idling on both streams. Uses the checker module and sitrd_pkg.
`timescale 1ns / 1ps

module signed_int_to_radix_digits_tb;
    import sitrd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int HOLDOFF      = 600;
    localparam int ITEMS_PER_MODE = 130;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   send_idle = 30;
    int                   recv_idle = 72;

    signed_int_to_radix_digits u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    signed_int_to_radix_digits_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_value(input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // Wait until every predicted character is out, then let any dropped values drain.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (HOLDOFF) @(posedge clk);
    endtask

    // Writes both alphabet words, then junk to an unmapped index that must be ignored.
    task automatic set_alphabet(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIGITS_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_DIGITS_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= $urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3;
        cfg_data  <= {$urandom, $urandom};
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void make_alphabet(input bit valid, output logic [CFG_W-1:0] lo,
                                          output logic [CFG_W-1:0] hi);
        logic [CHAR_W-1:0] sym [ALPHA_BYTES];
        int                r;
        int                k;
        int                j;
        bit                clash;
        case ($urandom_range(5))
            0:       r = 2;
            1:       r = ALPHA_BYTES;
            default: r = $urandom_range(ALPHA_BYTES, 2);
        endcase
        for (k = 0; k < ALPHA_BYTES; k++)
        begin
            sym[k] = $urandom_range(255);
        end
        for (k = 0; k < r; k++)
        begin
            do
            begin
                sym[k] = $urandom_range(255, 1);
                clash = (sym[k] == CHAR_PLUS || sym[k] == CHAR_MINUS);
                for (j = 0; j < k; j++)
                begin
                    if (sym[j] == sym[k])
                    begin
                        clash = 1'b1;
                    end
                end
            end
            while (clash);
        end
        if (r < ALPHA_BYTES)
        begin
            sym[r] = 8'h00;
        end
        if (!valid)
        begin
            case ($urandom_range(3))
                0:       sym[$urandom_range(1)] = 8'h00;
                1:       sym[$urandom_range(r - 1)] = CHAR_PLUS;
                2:       sym[$urandom_range(r - 1)] = CHAR_MINUS;
                default: sym[$urandom_range(r - 1, 1)] = sym[0];
            endcase
        end
        for (k = 0; k < ALPHA_BYTES; k++)
        begin
            if (k < 8)
            begin
                lo[8*k +: 8] = sym[k];
            end
            else
            begin
                hi[8*(k-8) +: 8] = sym[k];
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h0000_0000;
            4, 5:
            begin
                v = $urandom_range(300);
                if ($urandom_range(1))
                begin
                    v = 32'd0 - v;
                end
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        int               mode;
        int               counted;
        int               n;
        bit               use_valid;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset alphabet is empty, so these values are dropped.
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        // Single-digit alphabet, plus sign, minus sign, repeated digit.
        set_alphabet(64'h0000_0000_0000_0031, 64'h0);
        send_value(32'd7);
        set_alphabet(64'h3736_3534_2B32_3130, 64'h0000_0000_0000_3938);
        send_value(32'd42);
        set_alphabet(64'h3736_3534_3332_3130, 64'h0000_0000_0000_2D38);
        send_value(32'hFFFF_FFD6);
        set_alphabet(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3038);
        send_value(32'd99);
        // Decimal.
        set_alphabet(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd10);
        send_value(32'd0 - 32'd123456789);
        // Binary, with junk after the terminating zero byte that must be ignored.
        set_alphabet(64'h2B2D_3131_2B00_3130, 64'h2D2B_3030_2D2B_3131);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);
        send_value(32'd5);
        // Full sixteen-symbol hexadecimal alphabet.
        set_alphabet(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
        send_value(32'd15);
        send_value(32'd16);
        send_value(32'hDEAD_BEEF);
        // Symbols with the top bit set.
        set_alphabet(64'hF7F6_F5F4_F3F2_F1F0, 64'hFFFE_FDFC_FBFA_F9F8);
        send_value(32'h0FED_CBA9);
        send_value(32'hFFFF_FFFF);

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle = 30;
                    recv_idle = 72;
                end
                1:
                begin
                    send_idle = 72;
                    recv_idle = 30;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            counted = 0;
            while (counted < ITEMS_PER_MODE)
            begin
                use_valid = ($urandom_range(4) != 0);
                make_alphabet(use_valid, lo, hi);
                set_alphabet(lo, hi);
                n = use_valid ? 24 : 4;
                repeat (n) send_value(pick_value());
                if (use_valid)
                begin
                    counted += n;
                end
            end
        end

        wait_drain();
        if (fail_count == 0 && pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
